// ===== rtl/refraction_direction_unit_macros.svh =====
// ---------------------------------------------------------------------------
// Refraction direction unit assertion macros
// Same-cycle and next-cycle property wrappers; empty when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef REFRACTION_DIRECTION_UNIT_MACROS_SVH
`define REFRACTION_DIRECTION_UNIT_MACROS_SVH
`ifndef SYNTH
`define RDU_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define RDU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define RDU_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define RDU_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/rdu_pkg.sv =====
// ---------------------------------------------------------------------------
// Refraction direction unit package
// Constants and the link types passed between pipeline cells.
// ---------------------------------------------------------------------------
package rdu_pkg;

    localparam int DivCells  = 19;
    localparam int SqrtCells = 29;
    localparam logic [14:0] IndexMin = 15'd2048;

    typedef struct packed {
        logic [2:0][15:0] inc;
        logic [2:0][16:0] nrm;
        logic [14:0]      idx;
        logic [28:0]      cos28;
        logic             neg;
        logic [18:0]      eta;
        logic [46:0]      ec;
        logic             tir;
    } t_item;

    typedef struct packed {
        logic        valid;
        t_item       item;
        logic [29:0] rem;
        logic [32:0] dvs;
        logic [18:0] quo;
    } t_div_link;

    typedef struct packed {
        logic        valid;
        t_item       item;
        logic [57:0] rad;
        logic [57:0] res;
        logic [57:0] one;
    } t_sqrt_link;

endpackage

// ===== rtl/rdu_if.sv =====
// ---------------------------------------------------------------------------
// Refraction direction unit channels
// Valid/ready word channels for incoming rays and refracted results.
// ---------------------------------------------------------------------------
interface rdu_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] incident_x;
    logic signed [15:0] incident_y;
    logic signed [15:0] incident_z;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic        [14:0] index_ratio;
    modport source (output valid, incident_x, incident_y, incident_z,
                    normal_x, normal_y, normal_z, index_ratio, input ready);
    modport sink   (input valid, incident_x, incident_y, incident_z,
                    normal_x, normal_y, normal_z, index_ratio, output ready);
endinterface

interface rdu_out_if;
    logic               valid;
    logic               ready;
    logic signed [19:0] refracted_x;
    logic signed [19:0] refracted_y;
    logic signed [19:0] refracted_z;
    logic               total_reflection;
    modport source (output valid, refracted_x, refracted_y, refracted_z,
                    total_reflection, input ready);
    modport sink   (input valid, refracted_x, refracted_y, refracted_z,
                    total_reflection, output ready);
endinterface

// ===== rtl/rdu_div_cell.sv =====
// ---------------------------------------------------------------------------
// Divider cell
// One restoring quotient bit per cell; divisor halves towards the next cell.
// ---------------------------------------------------------------------------
module rdu_div_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  rdu_pkg::t_div_link i_link,
    output rdu_pkg::t_div_link o_link
);
    import rdu_pkg::*;

    t_div_link r_link;
    t_div_link n_link;
    logic      fits;

    always_comb begin
        fits   = {3'b000, i_link.rem} >= i_link.dvs;
        n_link = i_link;
        if (fits) begin
            n_link.rem = i_link.rem - i_link.dvs[29:0];
        end
        n_link.dvs = {1'b0, i_link.dvs[32:1]};
        n_link.quo = {i_link.quo[17:0], fits};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link.valid <= 1'b0;
        end else if (i_en) begin
            r_link <= n_link;
        end
    end

    assign o_link = r_link;
endmodule

// ===== rtl/rdu_sqrt_cell.sv =====
// ---------------------------------------------------------------------------
// Square root cell
// One result bit per cell of the digit-by-digit integer square root.
// ---------------------------------------------------------------------------
module rdu_sqrt_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  rdu_pkg::t_sqrt_link i_link,
    output rdu_pkg::t_sqrt_link o_link
);
    import rdu_pkg::*;

    t_sqrt_link  r_link;
    t_sqrt_link  n_link;
    logic [57:0] trial;

    always_comb begin
        trial  = i_link.res + i_link.one;
        n_link = i_link;
        if (i_link.rad >= trial) begin
            n_link.rad = i_link.rad - trial;
            n_link.res = {1'b0, i_link.res[57:1]} + i_link.one;
        end else begin
            n_link.res = {1'b0, i_link.res[57:1]};
        end
        n_link.one = {2'b00, i_link.one[57:2]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link.valid <= 1'b0;
        end else if (i_en) begin
            r_link <= n_link;
        end
    end

    assign o_link = r_link;
endmodule

// ===== rtl/refraction_direction_unit.sv =====
// ---------------------------------------------------------------------------
// Refraction direction unit
// Snell refraction of an incident direction about a surface normal.
// ---------------------------------------------------------------------------
// Usage: rays arrive on i_in (incident and normal in Q2.14, index in Q2.13),
// one word per accepted valid/ready handshake. Each word yields exactly one
// result word on o_out: the refracted direction in Q6.14, saturated, or a
// zero vector with total_reflection set when k is not positive.
// The path holds two front stages (products, dot and clamp), a row of 19
// divider cells forming 1/index, four arithmetic stages up to k, a row of
// 29 square root cells, and three back stages ending in the output register.
// Throughput, one word per cycle unless stalled; cell rows set latency only.
// The whole pipeline advances together whenever the output register is empty
// or being taken, so i_in.ready is low only while a result waits unread;
// a stalled receiver freezes every stage and nothing is lost or repeated.
// Reset clears all valid bits; data registers keep whatever they held.
// ---------------------------------------------------------------------------
`include "refraction_direction_unit_macros.svh"

module refraction_direction_unit (
    input  logic            i_clk,
    input  logic            i_rst_n,
    rdu_in_if.sink          i_in,
    rdu_out_if.source       o_out
);
    import rdu_pkg::*;

    logic en;

    // front: clamp index, form the three component products of the dot
    logic                   r_s1_valid;
    t_item                  r_s1_item;
    logic signed [2:0][31:0] r_s1_p;

    // dot, clamp, branch choice; feeds the divider row
    t_div_link  r_s2;
    t_div_link  w_div [0:DivCells];

    logic        r_s3_valid;
    t_item       r_s3_item;
    logic [57:0] r_s3_cc;

    logic        r_s4_valid;
    t_item       r_s4_item;
    logic [32:0] r_s4_eta2;
    logic [28:0] r_s4_sin2;

    logic        r_s5_valid;
    t_item       r_s5_item;
    logic [61:0] r_s5_prod;

    t_sqrt_link  r_s6;
    t_sqrt_link  w_sqrt [0:SqrtCells];

    logic               r_s7_valid;
    t_item              r_s7_item;
    logic signed [32:0] r_s7_mu;

    logic                    r_s8_valid;
    logic                    r_s8_tir;
    logic signed [2:0][35:0] r_s8_a;
    logic signed [2:0][49:0] r_s8_b;

    logic               r_out_valid;
    logic               r_out_tir;
    logic [2:0][19:0]   r_out_v;

    // stage combinational values
    t_item              n_s1_item;
    logic signed [2:0][31:0] n_s1_p;
    t_div_link          n_s2;
    logic signed [33:0] dot;
    logic signed [33:0] dotc;
    t_item              n_s3_item;
    logic [37:0]        eta_sq;
    t_item              n_s4_item;
    logic [46:0]        ec_prod;
    logic signed [62:0] k_val;
    t_sqrt_link         n_s6;
    logic [2:0][19:0]   n_out_v;
    logic signed [50:0] acc [0:2];
    logic signed [22:0] rnd [0:2];

    assign en         = !r_out_valid || o_out.ready;
    assign i_in.ready = en;

    always_comb begin
        n_s1_item        = '0;
        n_s1_item.inc[0] = i_in.incident_x;
        n_s1_item.inc[1] = i_in.incident_y;
        n_s1_item.inc[2] = i_in.incident_z;
        n_s1_item.nrm[0] = {i_in.normal_x[15], i_in.normal_x};
        n_s1_item.nrm[1] = {i_in.normal_y[15], i_in.normal_y};
        n_s1_item.nrm[2] = {i_in.normal_z[15], i_in.normal_z};
        n_s1_item.idx    = (i_in.index_ratio < IndexMin) ? IndexMin : i_in.index_ratio;
        n_s1_p[0]        = i_in.incident_x * i_in.normal_x;
        n_s1_p[1]        = i_in.incident_y * i_in.normal_y;
        n_s1_p[2]        = i_in.incident_z * i_in.normal_z;
    end

    // clamp the cosine to [-1, 1]; a zero cosine takes the direct branch
    always_comb begin
        dot = 34'($signed(r_s1_p[0])) + 34'($signed(r_s1_p[1]))
              + 34'($signed(r_s1_p[2]));
        if (dot > 34'sd268435456) begin
            dotc = 34'sd268435456;
        end else if (dot < -34'sd268435456) begin
            dotc = -34'sd268435456;
        end else begin
            dotc = dot;
        end
        n_s2            = '0;
        n_s2.valid      = r_s1_valid;
        n_s2.item       = r_s1_item;
        n_s2.item.neg   = dotc[33];
        n_s2.item.cos28 = dotc[33] ? 29'(-dotc) : dotc[28:0];
        n_s2.rem        = 30'h2000_0000;
        n_s2.dvs        = {r_s1_item.idx, 18'b0};
        n_s2.quo        = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (en) begin
            r_s1_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2.valid <= 1'b0;
        end else if (en) begin
            r_s2 <= n_s2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_item <= n_s1_item;
            r_s1_p    <= n_s1_p;
        end
    end

    assign w_div[0] = r_s2;

    genvar gi;
    generate
        for (gi = 0; gi < DivCells; gi++) begin : g_div
            rdu_div_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_en    (en),
                .i_link  (w_div[gi]),
                .o_link  (w_div[gi+1])
            );
        end
    endgenerate

    // pick eta and the normal's sign for the branch
    always_comb begin
        n_s3_item = w_div[DivCells].item;
        if (n_s3_item.neg) begin
            n_s3_item.eta = w_div[DivCells].quo;
        end else begin
            n_s3_item.eta = {1'b0, n_s3_item.idx, 3'b000};
            for (int j = 0; j < 3; j++) begin
                n_s3_item.nrm[j] = -n_s3_item.nrm[j];
            end
        end
    end

    assign eta_sq  = r_s3_item.eta * r_s3_item.eta;
    assign ec_prod = r_s3_item.eta * r_s3_item.cos28;
    assign k_val   = {7'b0000001, 56'b0} - {1'b0, r_s5_prod};

    always_comb begin
        n_s4_item    = r_s3_item;
        n_s4_item.ec = ec_prod;
    end

    always_comb begin
        n_s6          = '0;
        n_s6.valid    = r_s5_valid;
        n_s6.item     = r_s5_item;
        n_s6.item.tir = k_val[62] || (k_val == '0);
        n_s6.rad      = n_s6.item.tir ? '0 : {1'b0, k_val[56:0]};
        n_s6.res      = '0;
        n_s6.one      = {1'b0, 1'b1, 56'b0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
            r_s5_valid <= 1'b0;
        end else if (en) begin
            r_s3_valid <= w_div[DivCells].valid;
            r_s4_valid <= r_s3_valid;
            r_s5_valid <= r_s4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s6.valid <= 1'b0;
        end else if (en) begin
            r_s6 <= n_s6;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s3_item    <= n_s3_item;
            r_s3_cc      <= n_s3_item.cos28 * n_s3_item.cos28;
            r_s4_item    <= n_s4_item;
            r_s4_eta2    <= eta_sq[36:4];
            r_s4_sin2    <= 29'h1000_0000 - r_s3_cc[56:28];
            r_s5_item    <= r_s4_item;
            r_s5_prod    <= r_s4_eta2 * r_s4_sin2;
        end
    end

    assign w_sqrt[0] = r_s6;

    generate
        for (gi = 0; gi < SqrtCells; gi++) begin : g_sqrt
            rdu_sqrt_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_en    (en),
                .i_link  (w_sqrt[gi]),
                .o_link  (w_sqrt[gi+1])
            );
        end
    endgenerate

    // round to Q.14 by adding half and flooring, then saturate; zero on total reflection
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            acc[j] = 51'($signed(r_s8_a[j])) * 51'sd4096 + 51'($signed(r_s8_b[j]))
                     + 51'sd134217728;
            rnd[j] = acc[j][50:28];
            if (r_s8_tir) begin
                n_out_v[j] = '0;
            end else if (rnd[j] > 23'sd524287) begin
                n_out_v[j] = 20'h7FFFF;
            end else if (rnd[j] < -23'sd524288) begin
                n_out_v[j] = 20'h80000;
            end else begin
                n_out_v[j] = rnd[j][19:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s7_valid  <= 1'b0;
            r_s8_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_s7_valid  <= w_sqrt[SqrtCells].valid;
            r_s8_valid  <= r_s7_valid;
            r_out_valid <= r_s8_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s7_item <= w_sqrt[SqrtCells].item;
            r_s7_mu   <= $signed({2'b00, w_sqrt[SqrtCells].item.ec[46:16]})
                         - $signed({4'b0000, w_sqrt[SqrtCells].res[28:0]});
            r_s8_tir  <= r_s7_item.tir;
            for (int j = 0; j < 3; j++) begin
                r_s8_a[j] <= $signed({1'b0, r_s7_item.eta}) * $signed(r_s7_item.inc[j]);
                r_s8_b[j] <= r_s7_mu * $signed(r_s7_item.nrm[j]);
            end
            r_out_tir <= r_s8_tir;
            r_out_v   <= n_out_v;
        end
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.refracted_x      = r_out_v[0];
    assign o_out.refracted_y      = r_out_v[1];
    assign o_out.refracted_z      = r_out_v[2];
    assign o_out.total_reflection = r_out_tir;

    // input is open exactly when the pipeline may advance
    `RDU_ASSERT_NOW(a_ready_follows_out, i_clk, i_rst_n, 1'b1,
        i_in.ready == (!o_out.valid || o_out.ready))
    // total reflection always carries a zero vector
    `RDU_ASSERT_NOW(a_tir_zero, i_clk, i_rst_n, o_out.valid && o_out.total_reflection,
        o_out.refracted_x == 20'sd0 && o_out.refracted_y == 20'sd0 && o_out.refracted_z == 20'sd0)
    // a stall freezes the back stages after the root row
    `RDU_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, o_out.valid && !o_out.ready,
        $stable(r_s7_valid) && $stable(r_s8_valid))
endmodule

// ===== test/tb_rdu_pkg.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Refraction testbench types
// The ray word and the refraction result word used by driver and monitor.
// ---------------------------------------------------------------------------
package tb_rdu_pkg;

    typedef struct packed {
        logic signed [15:0] ix;
        logic signed [15:0] iy;
        logic signed [15:0] iz;
        logic signed [15:0] nx;
        logic signed [15:0] ny;
        logic signed [15:0] nz;
        logic        [14:0] idx;
    } t_ray;

    typedef struct packed {
        logic signed [19:0] rx;
        logic signed [19:0] ry;
        logic signed [19:0] rz;
        logic               tir;
    } t_refr;

endpackage

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Refraction direction unit testbench
// Drives ray words with random gaps, predicts each refracted direction in
// fixed point and compares it field by field against the output words.
// ---------------------------------------------------------------------------
module tb_top;
    import tb_rdu_pkg::*;

    localparam int  Latency   = 57;
    localparam int  CycleCap  = 400000;
    localparam int  NumRandom = 1630;

    logic i_clk;
    logic i_rst_n;

    rdu_in_if  ray_if ();
    rdu_out_if refr_if ();

    refraction_direction_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (ray_if.sink),
        .o_out   (refr_if.source)
    );

    t_ray  pending_rays[$];
    t_refr expected_dirs[$];
    int    fails;
    int    cycles;
    int    n_tir;
    int    n_checked;
    bit    stim_done;
    bit    calm;    // long stretch with no idling on either side

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Floor of the integer square root of a non-negative 64-bit value.
    function automatic longint unsigned isqrt_floor(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // Round a Q.42 accumulator to Q6.14 and saturate.
    function automatic logic signed [19:0] round_sat(longint acc);
        longint r;
        r = (acc + (64'sd1 <<< 27)) >>> 28;
        if (r > 524287)  r = 524287;
        if (r < -524288) r = -524288;
        return r[19:0];
    endfunction

    // Work out the refracted direction of one ray word.
    function automatic t_refr refract(t_ray w);
        longint inc[3], nrm[3];
        longint dot, cs, eta, eta2, sin2, k, mu, root;
        longint unsigned ix;
        t_refr o;
        inc[0] = w.ix; inc[1] = w.iy; inc[2] = w.iz;
        nrm[0] = w.nx; nrm[1] = w.ny; nrm[2] = w.nz;
        dot = inc[0]*nrm[0] + inc[1]*nrm[1] + inc[2]*nrm[2];
        ix = w.idx;
        if (ix < 2048) ix = 2048;
        // clamp the cosine to [-1, 1]
        if (dot > (64'sd1 <<< 28))  dot = 64'sd1 <<< 28;
        if (dot < -(64'sd1 <<< 28)) dot = -(64'sd1 <<< 28);
        if (dot < 0) begin
            // entering: ratio is 1/index, normal kept
            cs  = -dot;
            eta = longint'((64'd1 << 29) / ix);
        end else begin
            // leaving, or grazing at zero cosine: ratio is index, normal flipped
            cs  = dot;
            eta = longint'(ix << 3);
            for (int j = 0; j < 3; j++) nrm[j] = -nrm[j];
        end
        eta2 = (eta * eta) >>> 4;
        sin2 = (64'sd1 <<< 28) - ((cs * cs) >>> 28);
        k    = (64'sd1 <<< 56) - eta2 * sin2;
        o = '0;
        if (k <= 0) begin
            o.tir = 1'b1;
            return o;
        end
        root = longint'(isqrt_floor(longint'(k)));
        mu   = ((eta * cs) >>> 16) - root;
        o.rx = round_sat(eta * inc[0] * 4096 + mu * nrm[0]);
        o.ry = round_sat(eta * inc[1] * 4096 + mu * nrm[1]);
        o.rz = round_sat(eta * inc[2] * 4096 + mu * nrm[2]);
        return o;
    endfunction

    function automatic logic signed [15:0] rand_comp();
        return 16'($urandom);
    endfunction

    // Roughly unit vector components: mostly realistic directions.
    function automatic logic signed [15:0] unit_comp();
        return 16'($urandom_range(0, 32768) - 16384);
    endfunction

    function automatic logic [14:0] rand_index();
        case ($urandom_range(0, 9))
            0:       return 15'($urandom_range(0, 2047));   // below range
            1:       return 15'($urandom);
            default: return 15'($urandom_range(6000, 14000)); // glass-like
        endcase
    endfunction

    task automatic queue_ray(logic signed [15:0] ix, iy, iz, nx, ny, nz,
                             logic [14:0] idx);
        t_ray w;
        w = '{ix, iy, iz, nx, ny, nz, idx};
        pending_rays.push_back(w);
    endtask

    // Stimulus: directed corners, then random rays.
    initial begin
        logic signed [15:0] a, b;
        stim_done = 1'b0;
        // grazing and head-on cases, both branches
        queue_ray(16'sd0, -16'sd16384, 16'sd0, 16'sd0, 16'sd16384, 16'sd0, 15'd12288);
        queue_ray(16'sd0, 16'sd16384, 16'sd0, 16'sd0, 16'sd16384, 16'sd0, 15'd12288);
        queue_ray(16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd16384, 16'sd0, 15'd12288);
        // total internal reflection from a dense medium
        queue_ray(16'sd11585, 16'sd11585, 16'sd0, 16'sd0, 16'sd16384, 16'sd0, 15'd32767);
        // index extremes, including zero and just under range
        queue_ray(16'sd8000, -16'sd12000, 16'sd5000, 16'sd0, 16'sd16384, 16'sd0, 15'd0);
        queue_ray(16'sd8000, -16'sd12000, 16'sd5000, 16'sd0, 16'sd16384, 16'sd0, 15'd2047);
        queue_ray(16'sd8000, -16'sd12000, 16'sd5000, 16'sd0, 16'sd16384, 16'sd0, 15'd2048);
        queue_ray(16'sd8000, -16'sd12000, 16'sd5000, 16'sd0, 16'sd16384, 16'sd0, 15'd32767);
        // field extremes: clamp of the cosine and output saturation
        queue_ray(-16'sd32768, -16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767,
                  16'sd32767, 15'd2048);
        queue_ray(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767,
                  16'sd32767, 15'd32767);
        queue_ray(-16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768,
                  16'sd32767, 15'd2048);
        queue_ray(16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768, -16'sd32768,
                  -16'sd32768, 15'd32767);
        queue_ray(16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 15'd0);
        queue_ray(-16'sd1, -16'sd1, -16'sd1, -16'sd1, -16'sd1, -16'sd1, 15'h7fff);
        queue_ray(-16'sd32768, 16'sd0, 16'sd0, -16'sd32768, 16'sd0, 16'sd0, 15'd4096);
        queue_ray(16'sd32767, 16'sd0, 16'sd0, -16'sd32768, 16'sd0, 16'sd0, 15'd4096);
        for (int n = 0; n < NumRandom; n++) begin
            if ($urandom_range(0, 4) == 0) begin
                queue_ray(rand_comp(), rand_comp(), rand_comp(),
                          rand_comp(), rand_comp(), rand_comp(), 15'($urandom));
            end else begin
                a = unit_comp();
                b = unit_comp();
                queue_ray(a, b, unit_comp(), unit_comp(), unit_comp(), unit_comp(),
                          rand_index());
            end
        end
        stim_done = 1'b1;
    end

    // Reset and cycle count; reset is held low from the start, then released.
    initial begin
        i_rst_n = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        // quiet window with no idling on either side
        calm <= (cycles > 1000 && cycles < 2000);
    end

    // Driver: present the next ray, drop valid at random.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            ray_if.valid <= 1'b0;
        end else if (!ray_if.valid || ray_if.ready) begin
            if (ray_if.valid) expected_dirs.push_back(refract(pending_rays.pop_front()));
            if (pending_rays.size() > (ray_if.valid ? 0 : 0) &&
                (calm || $urandom_range(0, 99) >= 34)) begin
                ray_if.valid       <= 1'b1;
                ray_if.incident_x  <= pending_rays[0].ix;
                ray_if.incident_y  <= pending_rays[0].iy;
                ray_if.incident_z  <= pending_rays[0].iz;
                ray_if.normal_x    <= pending_rays[0].nx;
                ray_if.normal_y    <= pending_rays[0].ny;
                ray_if.normal_z    <= pending_rays[0].nz;
                ray_if.index_ratio <= pending_rays[0].idx;
            end else begin
                ray_if.valid <= 1'b0;
            end
        end
    end

    // Receiver: stall at random, check every taken result word.
    always @(posedge i_clk) begin
        t_refr want;
        int    bad;
        bad = 0;
        if (!i_rst_n) begin
            refr_if.ready <= 1'b0;
        end else begin
            if (refr_if.valid && refr_if.ready) begin
                if (expected_dirs.size() == 0) begin
                    $error("result word with nothing expected");
                    bad++;
                end else begin
                    want = expected_dirs.pop_front();
                    n_checked <= n_checked + 1;
                    if (want.tir) n_tir <= n_tir + 1;
                    if (refr_if.refracted_x !== want.rx) begin
                        $error("refracted_x: expected %0d, got %0d", want.rx,
                               refr_if.refracted_x);
                        bad++;
                    end
                    if (refr_if.refracted_y !== want.ry) begin
                        $error("refracted_y: expected %0d, got %0d", want.ry,
                               refr_if.refracted_y);
                        bad++;
                    end
                    if (refr_if.refracted_z !== want.rz) begin
                        $error("refracted_z: expected %0d, got %0d", want.rz,
                               refr_if.refracted_z);
                        bad++;
                    end
                    if (refr_if.total_reflection !== want.tir) begin
                        $error("total_reflection: expected %0d, got %0d", want.tir,
                               refr_if.total_reflection);
                        bad++;
                    end
                end
            end
            if (bad != 0) fails <= fails + bad;
            refr_if.ready <= calm || ($urandom_range(0, 99) >= 34);
        end
    end

    // Keep the idle payload known before the first word.
    initial begin
        fails = 0; cycles = 0; n_tir = 0; n_checked = 0; calm = 1'b0;
        ray_if.valid = 1'b0;
        refr_if.ready = 1'b0;
        ray_if.incident_x = '0; ray_if.incident_y = '0; ray_if.incident_z = '0;
        ray_if.normal_x = '0; ray_if.normal_y = '0; ray_if.normal_z = '0;
        ray_if.index_ratio = '0;
    end

    // End of run: drain, settle, report.
    initial begin
        wait (stim_done);
        while ((pending_rays.size() != 0 || ray_if.valid || expected_dirs.size() != 0)
               && cycles < CycleCap)
            @(posedge i_clk);
        if (cycles >= CycleCap) begin
            $display("timeout after %0d cycles", cycles);
            $display("*** FAILED ***");
            $finish;
        end else begin
            repeat (Latency + 10) @(posedge i_clk);
            $display("checked %0d refracted words, %0d of them total reflection",
                     n_checked, n_tir);
            if (fails == 0 && expected_dirs.size() == 0) begin
                $display("*** PASSED ***");
            end else begin
                $display("*** FAILED ***");
            end
            $finish;
        end
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/rdu_pkg.sv
rtl/rdu_if.sv
rtl/rdu_div_cell.sv
rtl/rdu_sqrt_cell.sv
rtl/refraction_direction_unit.sv
test/tb_rdu_pkg.sv
test/tb_top.sv
